>>> rtl/core/evfs_pkg.sv
package evfs_pkg;

  // Field widths of the check and report channels.
  localparam int unsigned VAR_W  = 16;
  localparam int unsigned ALT_W  = 20;
  localparam int unsigned TIME_W = 32;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_THRESHOLD  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WARNING_INTERVAL_MS = 1'd1;
  localparam logic [VAR_W-1:0]  VARIANCE_THRESHOLD_RESET  = 16'd205;
  localparam logic [TIME_W-1:0] WARNING_INTERVAL_MS_RESET = 32'd30000;

  localparam int unsigned FAIL_LIMIT_DEFAULT = 10;

  // Slew ratio in unsigned Q16, 65536 = 1.0.
  localparam int unsigned RATIO_W = 17;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 17'd32768;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 17'd65536;

  // Time ratio: floor(e * 65536 / 10000) = floor(e * 4096 / 625) for e below
  // 10000, done as (e * TIME_RECIP) >> TIME_SHIFT, exact over that range.
  localparam logic [TIME_W-1:0] SLEW_TIME_MS = 32'd10000;
  localparam int unsigned TIME_E_W   = 14;
  localparam int unsigned TIME_RCP_W = 27;
  localparam logic [TIME_RCP_W-1:0] TIME_RECIP = 27'd109951163;
  localparam int unsigned TIME_SHIFT = 24;

  // Altitude ratio: floor(c * 65536 / 1000) = floor(c * 8192 / 125) for c
  // below 1000, done as (c * ALT_RECIP) >> ALT_SHIFT.
  localparam int unsigned CLIMB_W   = ALT_W + 1;
  localparam logic [CLIMB_W-1:0] SLEW_ALT_CM = 21'd1000;
  localparam int unsigned ALT_C_W   = 10;
  localparam int unsigned ALT_RCP_W = 24;
  localparam logic [ALT_RCP_W-1:0] ALT_RECIP = 24'd8589935;
  localparam int unsigned ALT_SHIFT = 17;

endpackage

>>> rtl/core/evfs_check_if.sv
interface evfs_check_if import evfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              origin_valid;
  logic              landed;
  logic              altitude_valid;
  logic [ALT_W-1:0]  altitude_cm;
  logic [TIME_W-1:0] now_ms;
  logic [VAR_W-1:0]  velocity_variance;
  logic [VAR_W-1:0]  pos_variance;
  logic [VAR_W-1:0]  mag_variance_x;
  logic [VAR_W-1:0]  mag_variance_y;
  logic [VAR_W-1:0]  mag_variance_z;
  logic              flow_healthy;
  logic              position_known;

  modport source (
    output valid, origin_valid, landed, altitude_valid, altitude_cm, now_ms,
           velocity_variance, pos_variance, mag_variance_x, mag_variance_y,
           mag_variance_z, flow_healthy, position_known,
    input  ready
  );

  modport sink (
    input  valid, origin_valid, landed, altitude_valid, altitude_cm, now_ms,
           velocity_variance, pos_variance, mag_variance_x, mag_variance_y,
           mag_variance_z, flow_healthy, position_known,
    output ready
  );
endinterface

>>> rtl/core/evfs_report_if.sv
interface evfs_report_if import evfs_pkg::*; ();
  logic valid;
  logic ready;
  logic estimate_bad;
  logic failsafe_active;
  logic failsafe_raised;
  logic failsafe_cleared;
  logic yaw_reset_request;
  logic lane_switch_request;
  logic warning_pulse;

  modport source (
    output valid, estimate_bad, failsafe_active, failsafe_raised, failsafe_cleared,
           yaw_reset_request, lane_switch_request, warning_pulse,
    input  ready
  );

  modport sink (
    input  valid, estimate_bad, failsafe_active, failsafe_raised, failsafe_cleared,
           yaw_reset_request, lane_switch_request, warning_pulse,
    output ready
  );
endinterface

>>> rtl/core/estimator_variance_failsafe_monitor.sv
// Estimator variance failsafe monitor.
// The check channel takes one transaction per estimator check: variances,
// altitude, time and status flags. The report channel returns exactly one
// transaction per check with the bad flag, the failsafe latch and the pulses
// raised by that check. The configuration port writes the variance threshold
// (index 0) and the warning interval (index 1) at any edge with cfg_we high.
// A check accepted on the check channel is captured in the middle register
// and then moved into the report register, which drives the report channel.
// Throughput is one check per cycle while reports are taken. The first stage
// holds the slew ratio loop (elapsed-time and climb reciprocal multiplies
// and a max/clamp); the second holds the threshold multiply, the vote and
// the fail counter loop. When the receiver stalls, the report register holds
// its transaction and the check channel accepts only while the middle stage
// is empty; with both stages full, ready drops until the report is taken.
// Synchronous reset clears all state and both stages, and restores the
// register reset values (threshold 205, warning interval 30000 ms).
module estimator_variance_failsafe_monitor import evfs_pkg::*; #(
  parameter int unsigned FAIL_LIMIT = FAIL_LIMIT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  evfs_check_if.sink             check,
  evfs_report_if.source          report,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(FAIL_LIMIT + 1);
  localparam logic [CNT_W:0] LIMIT    = (CNT_W+1)'(FAIL_LIMIT);
  localparam logic [CNT_W:0] LIMIT_M1 = (CNT_W+1)'(FAIL_LIMIT - 1);
  localparam logic [CNT_W:0] LIMIT_M2 = (CNT_W+1)'(FAIL_LIMIT - 2);

  function automatic logic [RATIO_W-1:0] clamp_ratio(input logic [RATIO_W-1:0] r);
    logic [RATIO_W-1:0] c;
    if (r < RATIO_MIN) begin
      c = RATIO_MIN;
    end else if (r > RATIO_MAX) begin
      c = RATIO_MAX;
    end else begin
      c = r;
    end
    return c;
  endfunction

  // Configuration registers.
  logic [VAR_W-1:0]  variance_threshold;
  logic [TIME_W-1:0] warning_interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      variance_threshold  <= VARIANCE_THRESHOLD_RESET;
      warning_interval_ms <= WARNING_INTERVAL_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VARIANCE_THRESHOLD:  variance_threshold  <= cfg_data[VAR_W-1:0];
        REG_WARNING_INTERVAL_MS: warning_interval_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  logic threshold_zero;
  assign threshold_zero = (variance_threshold == '0);

  // Handshake and stage flow.
  logic m_valid, o_valid;
  logic o_load, m_load;
  assign o_load = !o_valid || report.ready;
  assign m_load = !m_valid || o_load;
  assign check.ready = m_load;

  logic accept, m_move;
  assign accept = check.valid && m_load;
  assign m_move = m_valid && o_load;

  // ---------------- Stage 1: slew ratio ----------------
  logic [RATIO_W-1:0] slew_ratio, slew_ratio_next;
  logic [TIME_W-1:0]  takeoff_ms;
  logic [ALT_W-1:0]   takeoff_altitude_cm;

  logic [TIME_W-1:0]               elapsed;
  logic [TIME_E_W+TIME_RCP_W-1:0]  time_prod;
  logic [RATIO_W-1:0]              elapsed_ratio;
  logic signed [CLIMB_W-1:0]       climb;
  logic [ALT_C_W+ALT_RCP_W-1:0]    alt_prod;
  logic [RATIO_W-1:0]              climb_ratio;
  logic [RATIO_W-1:0]              best;

  assign elapsed   = check.now_ms - takeoff_ms;
  assign time_prod = elapsed[TIME_E_W-1:0] * TIME_RECIP;
  assign climb     = $signed({check.altitude_cm[ALT_W-1], check.altitude_cm})
                   - $signed({takeoff_altitude_cm[ALT_W-1], takeoff_altitude_cm});
  assign alt_prod  = climb[ALT_C_W-1:0] * ALT_RECIP;

  always_comb begin
    if (elapsed >= SLEW_TIME_MS) begin
      elapsed_ratio = RATIO_MAX;
    end else begin
      elapsed_ratio = {1'b0, time_prod[TIME_SHIFT +: RATIO_W-1]};
    end

    // A negative climb can never win over the floor of the ratio.
    if (!check.altitude_valid) begin
      climb_ratio = RATIO_MAX;
    end else if (climb[CLIMB_W-1] || climb == '0) begin
      climb_ratio = '0;
    end else if (climb >= $signed(SLEW_ALT_CM)) begin
      climb_ratio = RATIO_MAX;
    end else begin
      climb_ratio = {1'b0, alt_prod[ALT_SHIFT +: RATIO_W-1]};
    end

    best = slew_ratio;
    if (elapsed_ratio > best) best = elapsed_ratio;
    if (climb_ratio > best) best = climb_ratio;

    priority if (threshold_zero) begin
      slew_ratio_next = RATIO_MAX;
    end else if (check.landed) begin
      slew_ratio_next = RATIO_MIN;
    end else if (slew_ratio < RATIO_MAX) begin
      slew_ratio_next = clamp_ratio(best);
    end else begin
      slew_ratio_next = slew_ratio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_ratio          <= '0;
      takeoff_ms          <= '0;
      takeoff_altitude_cm <= '0;
    end else if (accept && check.origin_valid) begin
      slew_ratio <= slew_ratio_next;
      if (!threshold_zero && check.landed) begin
        takeoff_ms          <= check.now_ms;
        takeoff_altitude_cm <= check.altitude_valid ? check.altitude_cm : '0;
      end
    end
  end

  logic [VAR_W-1:0] mag_max;
  always_comb begin
    mag_max = (check.mag_variance_x > check.mag_variance_y) ? check.mag_variance_x
                                                            : check.mag_variance_y;
    if (check.mag_variance_z > mag_max) mag_max = check.mag_variance_z;
  end

  // Middle register.
  logic               m_origin;
  logic [RATIO_W-1:0] m_ratio;
  logic [VAR_W-1:0]   m_vel, m_pos, m_mag;
  logic               m_flow, m_has_pos;
  logic [TIME_W-1:0]  m_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_load) begin
      m_valid <= check.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_origin  <= check.origin_valid;
      m_ratio   <= clamp_ratio(slew_ratio_next);
      m_vel     <= check.velocity_variance;
      m_pos     <= check.pos_variance;
      m_mag     <= mag_max;
      m_flow    <= check.flow_healthy;
      m_has_pos <= check.position_known;
      m_now     <= check.now_ms;
    end
  end

  // ---------------- Stage 2: vote and fail counter ----------------
  logic [CNT_W-1:0]  fail_counter, fail_counter_next;
  logic              bad_flag, bad_flag_next;
  logic              ever_passed, ever_passed_next;
  logic              failsafe_latch, failsafe_latch_next;
  logic [TIME_W-1:0] last_warning_ms, last_warning_ms_next;
  logic raised, cleared, yaw_req, lane_req, warn;

  logic [VAR_W+RATIO_W-1:0] thr;
  logic [VAR_W+RATIO_W:0]   thr2;
  logic [VAR_W+RATIO_W:0]   vel_s, pos_s, mag_s;
  logic                     mag_over, vel_over, vel_over2, pos_over;
  logic [1:0]               votes;
  logic                     over, passed;
  logic [CNT_W:0]           cnt_inc;
  logic [CNT_W-1:0]         cnt_dec;
  logic [TIME_W-1:0]        since_warning;

  assign thr    = variance_threshold * m_ratio;
  assign thr2   = {thr, 1'b0};
  assign vel_s  = {{(RATIO_W-VAR_W+1){1'b0}}, m_vel, {VAR_W{1'b0}}};
  assign pos_s  = {{(RATIO_W-VAR_W+1){1'b0}}, m_pos, {VAR_W{1'b0}}};
  assign mag_s  = {{(RATIO_W-VAR_W+1){1'b0}}, m_mag, {VAR_W{1'b0}}};

  assign mag_over  = mag_s >= {1'b0, thr};
  assign vel_over  = vel_s >= {1'b0, thr};
  assign vel_over2 = vel_s >= thr2;
  assign pos_over  = pos_s >= {1'b0, thr};

  // Without a healthy flow sensor, a very large velocity variance fails alone.
  always_comb begin
    votes = {1'b0, mag_over};
    if (!m_flow && vel_over2) begin
      votes = votes + 2'd2;
    end else if (vel_over) begin
      votes = votes + 2'd1;
    end
  end

  assign over          = (pos_over && votes >= 2'd1) || votes >= 2'd2;
  assign passed        = !over && m_has_pos;
  assign cnt_inc       = {1'b0, fail_counter} + 1'b1;
  assign cnt_dec       = fail_counter - 1'b1;
  assign since_warning = m_now - last_warning_ms;

  always_comb begin
    fail_counter_next    = fail_counter;
    bad_flag_next        = bad_flag;
    ever_passed_next     = ever_passed;
    failsafe_latch_next  = failsafe_latch;
    last_warning_ms_next = last_warning_ms;
    raised   = 1'b0;
    cleared  = 1'b0;
    yaw_req  = 1'b0;
    lane_req = 1'b0;
    warn     = 1'b0;

    if (m_origin) begin
      if (threshold_zero) begin
        fail_counter_next   = '0;
        bad_flag_next       = 1'b0;
        failsafe_latch_next = 1'b0;
        cleared             = failsafe_latch;
      end else begin
        ever_passed_next = ever_passed || passed;
        if (ever_passed_next) begin
          if (!passed) begin
            if (!bad_flag) begin
              fail_counter_next = cnt_inc[CNT_W-1:0];
              yaw_req  = (cnt_inc == LIMIT_M2) && over;
              lane_req = (cnt_inc == LIMIT_M1);
              if (cnt_inc >= LIMIT) begin
                fail_counter_next = LIMIT[CNT_W-1:0];
                bad_flag_next     = 1'b1;
                if (since_warning > warning_interval_ms) begin
                  warn                 = 1'b1;
                  last_warning_ms_next = m_now;
                end
                failsafe_latch_next = 1'b1;
                raised              = !failsafe_latch;
              end
            end
          end else if (fail_counter != '0) begin
            fail_counter_next = cnt_dec;
            if (bad_flag && cnt_dec == '0) begin
              bad_flag_next       = 1'b0;
              failsafe_latch_next = 1'b0;
              cleared             = failsafe_latch;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_counter    <= '0;
      bad_flag        <= 1'b0;
      ever_passed     <= 1'b0;
      failsafe_latch  <= 1'b0;
      last_warning_ms <= '0;
    end else if (m_move) begin
      fail_counter    <= fail_counter_next;
      bad_flag        <= bad_flag_next;
      ever_passed     <= ever_passed_next;
      failsafe_latch  <= failsafe_latch_next;
      last_warning_ms <= last_warning_ms_next;
    end
  end

  // Report register.
  logic o_bad, o_active, o_raised, o_cleared, o_yaw, o_lane, o_warn;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_move) begin
      o_bad     <= bad_flag_next;
      o_active  <= failsafe_latch_next;
      o_raised  <= raised;
      o_cleared <= cleared;
      o_yaw     <= yaw_req;
      o_lane    <= lane_req;
      o_warn    <= warn;
    end
  end

  assign report.valid               = o_valid;
  assign report.estimate_bad        = o_bad;
  assign report.failsafe_active     = o_active;
  assign report.failsafe_raised     = o_raised;
  assign report.failsafe_cleared    = o_cleared;
  assign report.yaw_reset_request   = o_yaw;
  assign report.lane_switch_request = o_lane;
  assign report.warning_pulse       = o_warn;

endmodule
